### sv/aslls_pkg.sv
// shared types and constants for the console line store
`default_nettype none
package aslls_pkg;
    localparam int STORE_DEPTH = 4096;
    localparam int LINE_BYTES  = 256;
    localparam int SA_W = $clog2(STORE_DEPTH);
    localparam int LA_W = $clog2(LINE_BYTES);
    localparam int CNT_W = SA_W + 1;
    localparam int LEN_W = LA_W + 1;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LB  = 8'h5B;
    localparam logic [7:0] CH_AT  = 8'h40;
    localparam logic [7:0] CH_TIL = 8'h7E;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_ONE  = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;

    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FEED, ST_INJECT, ST_CLIP, ST_EVCHK, ST_EVRD, ST_EVWAIT,
        ST_EVBYTE, ST_COPYRD, ST_COPYWR, ST_TERM, ST_RDWAIT, ST_RDDATA, ST_OUT
    } state_t;
endpackage
`default_nettype wire

### sv/ansi_strip_line_log_store_unit.sv
// top level: ansi escape filter feeding a ring store of terminated lines
//
// usage: one input transfer per item on s_axis (cmd, data_byte, record_end,
// record_incomplete, read_index). every item yields exactly one result
// transfer on m_axis with the read byte, valid flag and counters.
// a feed item that commits no line only updates the filter and line buffer; a
// newline that commits a line evicts old bytes by read, wait and check steps
// and copies the line buffer by a read and a write step per byte, so latency
// grows with line length plus evicted bytes. a read item uses the ram read port.
// one item is worked on at a time; s_axis_tready is low while busy and while
// a result waits. when the receiver stalls the result holds in m_axis
// registers until taken. store_capacity is written on the cfg channel while
// idle. synchronous active-low reset clears all control and counters and
// sets the capacity to the store depth; stored bytes are not cleared.
`default_nettype none
module ansi_strip_line_log_store_unit
    import aslls_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] cmd, [8:1] data_byte, [9] record_end, [10] record_incomplete,
    // [22:11] read_index, [23] zero
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_byte, [8] read_valid, [21:9] used_bytes, [33:22] line_count,
    // [65:34] dropped_count, [97:66] total_count, [103:98] zero
    output logic [103:0]     m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);
    state_t state_reg, state_next;
    logic [12:0] cap_reg;
    logic [1:0]  esc_reg, esc_next;
    logic        drop_reg, drop_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SA_W-1:0]  old_reg, old_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [11:0] lines_reg, lines_next;
    logic [31:0] evict_reg, evict_next, commit_reg, commit_next;
    // item fields
    logic        inj_reg, inj_next;
    logic [7:0]  byte_reg, byte_next;
    logic [11:0] ridx_reg;
    // commit work
    logic [CNT_W-1:0] clen_reg, clen_next, cnt_reg, cnt_next;
    logic [CNT_W-1:0] ecap_reg;
    // result
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        rvalid_reg, rvalid_next;
    logic        mval_reg;

    logic [7:0] lbuf [LINE_BYTES];
    logic [7:0] lbuf_q;
    logic       lb_we;
    logic [LA_W-1:0] lb_waddr, lb_raddr;

    logic            st_we;
    logic [SA_W-1:0] st_waddr, st_raddr;
    logic [7:0]      st_wdata, st_q;

    aslls_store_ram u_ram (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_q)
    );

    always_ff @(posedge aclk) begin
        if (lb_we) lbuf[lb_waddr] <= byte_reg;
        lbuf_q <= lbuf[lb_raddr];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {6'd0, commit_reg, evict_reg, lines_reg,
                            {{(13-CNT_W){1'b0}}, used_reg}, rvalid_reg, rbyte_reg};

    // shared add/compare: fit check of used + len + 1 against capacity
    logic [CNT_W+1:0] need;
    assign need = {2'b0, used_reg} + {2'b0, clen_reg} + 1'b1;
    logic [CNT_W-1:0] ecap_w;
    assign ecap_w = (cap_reg > 13'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                 : CNT_W'(cap_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_axis_tvalid)
                           state_next = (s_axis_tdata[0] == CMD_READ) ? ST_RDWAIT : ST_FEED;
            ST_FEED, ST_INJECT: begin
                if (esc_reg == ESC_NONE && byte_reg == CH_NL ||
                    esc_reg == ESC_CSI && byte_reg == CH_NL) begin
                    if (len_reg != '0 && ecap_reg != '0) state_next = ST_CLIP;
                    else if (inj_reg && state_reg == ST_FEED) state_next = ST_INJECT;
                    else state_next = ST_OUT;
                end else if (inj_reg && state_reg == ST_FEED) state_next = ST_INJECT;
                else state_next = ST_OUT;
            end
            ST_CLIP:   state_next = ST_EVCHK;
            ST_EVCHK:  if (need > {2'b0, ecap_reg})
                           state_next = (lines_reg != '0) ? ST_EVRD
                                      : (inj_reg ? ST_INJECT : ST_OUT);
                       else state_next = (clen_reg != '0) ? ST_COPYRD : ST_TERM;
            ST_EVRD:   state_next = ST_EVWAIT;
            ST_EVWAIT: state_next = ST_EVBYTE;
            ST_EVBYTE: if (st_q == 8'd0 || cnt_reg + 1'b1 >= used_reg)
                           state_next = ST_EVCHK;
                       else state_next = ST_EVRD;
            ST_COPYRD: state_next = ST_COPYWR;
            ST_COPYWR: state_next = (cnt_reg + 1'b1 >= clen_reg) ? ST_TERM : ST_COPYRD;
            ST_TERM:   state_next = inj_reg ? ST_INJECT : ST_OUT;
            ST_RDWAIT: state_next = ST_RDDATA;
            ST_RDDATA: state_next = ST_OUT;
            ST_OUT:    if (m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        esc_next = esc_reg; drop_next = drop_reg; len_next = len_reg;
        old_next = old_reg; used_next = used_reg; lines_next = lines_reg;
        evict_next = evict_reg; commit_next = commit_reg;
        inj_next = inj_reg; byte_next = byte_reg;
        clen_next = clen_reg; cnt_next = cnt_reg;
        rbyte_next = rbyte_reg; rvalid_next = rvalid_reg;
        lb_we = 1'b0; lb_waddr = len_reg[LA_W-1:0]; lb_raddr = cnt_reg[LA_W-1:0];
        st_we = 1'b0; st_wdata = lbuf_q;
        st_waddr = SA_W'(old_reg + used_reg[SA_W-1:0] + cnt_reg[SA_W-1:0]);
        st_raddr = SA_W'(old_reg + cnt_reg[SA_W-1:0]);
        case (state_reg)
            ST_IDLE: begin
                rbyte_next = 8'd0; rvalid_next = 1'b0;
                byte_next = s_axis_tdata[8:1];
                inj_next = s_axis_tdata[9] & s_axis_tdata[10];
            end
            ST_FEED, ST_INJECT: begin
                if (state_reg == ST_INJECT) inj_next = 1'b0;
                else if (!inj_reg) inj_next = 1'b0;
                // the injected newline is taken up in the inject pass
                if (state_reg == ST_FEED && inj_reg) byte_next = CH_NL;
                case (esc_reg)
                    ESC_ONE: esc_next = (byte_reg == CH_LB) ? ESC_CSI : ESC_NONE;
                    ESC_CSI: begin
                        if (byte_reg == CH_NL || (byte_reg >= CH_AT && byte_reg <= CH_TIL))
                            esc_next = ESC_NONE;
                    end
                    default: begin
                        esc_next = ESC_NONE;
                        if (byte_reg == CH_ESC) esc_next = ESC_ONE;
                        else if (byte_reg == CH_CR || byte_reg == CH_NUL
                                 || byte_reg == CH_NL) ;
                        else if (!drop_reg) begin
                            if (32'(len_reg) + 1 >= LINE_BYTES) drop_next = 1'b1;
                            else begin lb_we = 1'b1; len_next = len_reg + 1'b1; end
                        end
                    end
                endcase
                if ((esc_reg == ESC_NONE || esc_reg == ESC_CSI || esc_reg == 2'd3)
                    && byte_reg == CH_NL) begin
                    clen_next = CNT_W'(len_reg);
                    len_next = '0; drop_next = 1'b0;
                end
                cnt_next = '0;
            end
            ST_CLIP: if ({1'b0, clen_reg} + 1'b1 > {1'b0, ecap_reg})
                         clen_next = ecap_reg - 1'b1;
            ST_EVCHK: begin
                cnt_next = '0;
                if (need > {2'b0, ecap_reg} && lines_reg != '0) begin
                    lines_next = lines_reg - 1'b1; evict_next = evict_reg + 1'b1;
                end
            end
            ST_EVBYTE: begin
                if (st_q == 8'd0 || cnt_reg + 1'b1 >= used_reg) begin
                    old_next = SA_W'(old_reg + cnt_reg[SA_W-1:0] + 1'b1);
                    used_next = used_reg - cnt_reg - 1'b1;
                end else cnt_next = cnt_reg + 1'b1;
            end
            ST_COPYWR: begin
                st_we = 1'b1; cnt_next = cnt_reg + 1'b1;
            end
            ST_TERM: begin
                st_we = 1'b1; st_wdata = 8'd0;
                st_waddr = SA_W'(old_reg + used_reg[SA_W-1:0] + clen_reg[SA_W-1:0]);
                used_next = used_reg + clen_reg + 1'b1;
                lines_next = lines_reg + 1'b1; commit_next = commit_reg + 1'b1;
            end
            ST_RDWAIT: st_raddr = SA_W'(old_reg + ridx_reg[SA_W-1:0]);
            ST_RDDATA: if (CNT_W'(ridx_reg) < used_reg) begin
                           rbyte_next = st_q; rvalid_next = 1'b1;
                       end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; cap_reg <= 13'(STORE_DEPTH);
            esc_reg <= ESC_NONE; drop_reg <= 1'b0; len_reg <= '0;
            old_reg <= '0; used_reg <= '0; lines_reg <= '0;
            evict_reg <= '0; commit_reg <= '0; mval_reg <= 1'b0; inj_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
            esc_reg <= esc_next; drop_reg <= drop_next; len_reg <= len_next;
            old_reg <= old_next; used_reg <= used_next; lines_reg <= lines_next;
            evict_reg <= evict_next; commit_reg <= commit_next; inj_reg <= inj_next;
            mval_reg <= (state_next == ST_OUT);
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next; clen_reg <= clen_next; cnt_reg <= cnt_next;
        rbyte_reg <= rbyte_next; rvalid_reg <= rvalid_next;
        ecap_reg <= ecap_w;
        if (state_reg == ST_IDLE) begin
            ridx_reg <= s_axis_tdata[22:11];
        end
    end
endmodule
`default_nettype wire

### sv/aslls_store_ram.sv
// line store ram: one write port, one registered read port
`default_nettype none
module aslls_store_ram
    import aslls_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [SA_W-1:0] waddr,
    input  wire logic [7:0]      wdata,
    input  wire logic [SA_W-1:0] raddr,
    output logic      [7:0]      rdata
);
    logic [7:0] mem [STORE_DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/aslls_checker.sv
// port-level checks for the line store unit
`default_nettype none
module aslls_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);
    a_no_accept_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept with result pending");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_valid_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("byte without valid");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[21:9] <= 13'd4096) else $error("used overflow");
endmodule
bind ansi_strip_line_log_store_unit aslls_checker u_chk (.*);
`default_nettype wire

### tb/sv/tb.sv
// testbench for the console line store: ansi filtering, line commit, eviction and reads
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import aslls_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic        record_end;
        logic        record_incomplete;
        logic [11:0] read_index;
    } item_t;

    // highest field first so the layout matches m_axis_tdata
    typedef struct packed {
        logic [31:0] total_count;
        logic [31:0] dropped_count;
        logic [11:0] line_count;
        logic [12:0] used_bytes;
        logic        read_valid;
        logic [7:0]  read_byte;
    } status_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [12:0]  cfg_data = '0;

    ansi_strip_line_log_store_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [12:0] cap_reg;
    logic [1:0]  esc_phase;
    logic        tail_drop;
    int          buf_len;
    logic [7:0]  line_buf [LINE_BYTES];
    logic [7:0]  ring [STORE_DEPTH];
    int          head_ptr, held_bytes, held_lines;
    logic [31:0] evicted_lines, committed_lines;

    item_t   send_q[$];
    status_t status_q[$];
    int      errors = 0;
    int      results_seen = 0;
    int      reads_hit = 0;
    bit      calm = 1'b0;
    bit      in_taken = 1'b0;
    int      src_hold = 0, sink_hold = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        errors++;
    endtask

    function automatic bit drop_head_line();
        int n;
        logic [7:0] b;
        n = 0;
        if (held_lines == 0) return 1'b0;
        while (n < held_bytes) begin
            b = ring[(head_ptr + n) % STORE_DEPTH];
            n++;
            if (b == CH_NUL) break;
        end
        head_ptr = (head_ptr + n) % STORE_DEPTH;
        held_bytes -= n;
        held_lines--;
        evicted_lines++;
        return 1'b1;
    endfunction

    function automatic void commit_buffered_line();
        int len, lim, base;
        len = buf_len;
        lim = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : int'(cap_reg);
        buf_len = 0;
        tail_drop = 1'b0;
        if (len == 0 || lim == 0) return;
        if (len + 1 > lim) len = lim - 1;
        while (held_bytes + len + 1 > lim)
            if (!drop_head_line()) break;
        if (held_bytes + len + 1 > lim) return;
        base = head_ptr + held_bytes;
        for (int i = 0; i < len; i++) ring[(base + i) % STORE_DEPTH] = line_buf[i];
        ring[(base + len) % STORE_DEPTH] = CH_NUL;
        held_bytes += len + 1;
        held_lines++;
        committed_lines++;
    endfunction

    function automatic void filter_char(input logic [7:0] c);
        if (esc_phase == ESC_ONE) begin
            esc_phase = (c == CH_LB) ? ESC_CSI : ESC_NONE;
            return;
        end
        if (esc_phase == ESC_CSI) begin
            if (c != CH_NL) begin
                if (c >= CH_AT && c <= CH_TIL) esc_phase = ESC_NONE;
                return;
            end
        end
        esc_phase = ESC_NONE;
        if (c == CH_ESC) begin
            esc_phase = ESC_ONE;
            return;
        end
        if (c == CH_NL) begin
            commit_buffered_line();
            return;
        end
        if (c == CH_CR || c == CH_NUL || tail_drop) return;
        if (buf_len + 1 >= LINE_BYTES) begin
            tail_drop = 1'b1;
            return;
        end
        line_buf[buf_len] = c;
        buf_len++;
    endfunction

    function automatic status_t predict_status(input item_t it);
        status_t r;
        r = '0;
        if (it.cmd == CMD_FEED) begin
            filter_char(it.data_byte);
            if (it.record_end && it.record_incomplete) filter_char(CH_NL);
        end else if (int'(it.read_index) < held_bytes) begin
            r.read_byte = ring[(head_ptr + it.read_index) % STORE_DEPTH];
            r.read_valid = 1'b1;
        end
        r.used_bytes = held_bytes[12:0];
        r.line_count = held_lines[11:0];
        r.dropped_count = evicted_lines;
        r.total_count = committed_lines;
        return r;
    endfunction

    // driver: one transfer per item, random gaps until the calm tail
    always @(negedge aclk) begin
        if (aresetn) begin
            if (src_hold > 0) src_hold--;
            else if (!calm && $urandom_range(0, 5) == 0) src_hold = $urandom_range(1, 4);
            // an offered item stays until its transfer
            if (!s_axis_tvalid || in_taken) begin
                if (send_q.size() != 0 && src_hold == 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {1'b0, send_q[0].read_index,
                                      send_q[0].record_incomplete, send_q[0].record_end,
                                      send_q[0].data_byte, send_q[0].cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            in_taken = 1'b0;
            if (sink_hold > 0) sink_hold--;
            else if (!calm && $urandom_range(0, 4) == 0) sink_hold = $urandom_range(1, 4);
            m_axis_tready <= (sink_hold == 0);
        end
    end

    // predict on the accepted input transfer
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            status_q.push_back(predict_status(item_t'({s_axis_tdata[0], s_axis_tdata[8:1],
                s_axis_tdata[9], s_axis_tdata[10], s_axis_tdata[22:11]})));
            void'(send_q.pop_front());
            in_taken = 1'b1;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        status_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[97:0];
            if (status_q.size() == 0) begin
                report("unexpected result", 32'd0, 32'd0);
            end else begin
                want = status_q.pop_front();
                if (want.read_valid) reads_hit++;
                if (got.read_byte != want.read_byte)
                    report("read_byte", 32'(got.read_byte), 32'(want.read_byte));
                if (got.read_valid != want.read_valid)
                    report("read_valid", 32'(got.read_valid), 32'(want.read_valid));
                if (got.used_bytes != want.used_bytes)
                    report("used_bytes", 32'(got.used_bytes), 32'(want.used_bytes));
                if (got.line_count != want.line_count)
                    report("line_count", 32'(got.line_count), 32'(want.line_count));
                if (got.dropped_count != want.dropped_count)
                    report("dropped_count", got.dropped_count, want.dropped_count);
                if (got.total_count != want.total_count)
                    report("total_count", got.total_count, want.total_count);
            end
            results_seen++;
        end
    end

    function automatic item_t feed_item(input logic [7:0] c, input bit rend, input bit rinc);
        item_t it;
        it = '0;
        it.cmd = CMD_FEED;
        it.data_byte = c;
        it.record_end = rend;
        it.record_incomplete = rinc;
        it.read_index = 12'($urandom());
        return it;
    endfunction

    function automatic item_t read_item(input logic [11:0] idx);
        item_t it;
        it = '0;
        it.cmd = CMD_READ;
        it.data_byte = 8'($urandom());
        it.record_end = 1'($urandom());
        it.record_incomplete = 1'($urandom());
        it.read_index = idx;
        return it;
    endfunction

    // reads mostly land inside the held bytes, sometimes anywhere
    function automatic logic [11:0] pick_index();
        if (held_bytes > 0 && $urandom_range(0, 3) != 0)
            return 12'($urandom_range(0, held_bytes - 1));
        return 12'($urandom());
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 9))
            0: return CH_CR;
            1: return 8'($urandom());
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // queue one line of text with optional escapes, ended by newline or cut-off record
    task automatic queue_line(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_q.push_back(feed_item(CH_ESC, 0, 0));
                if ($urandom_range(0, 2) != 0) begin
                    send_q.push_back(feed_item(CH_LB, 0, 0));
                    send_q.push_back(feed_item(8'($urandom_range(8'h30, 8'h3F)), 0, 0));
                    send_q.push_back(feed_item(8'($urandom_range(CH_AT, CH_TIL)), 0, 0));
                end else send_q.push_back(feed_item(text_char(), 0, 0));
            end else send_q.push_back(feed_item(text_char(), 0, 0));
        end
        if ($urandom_range(0, 1)) send_q.push_back(feed_item(CH_NL, 1'($urandom()), 0));
        else send_q.push_back(feed_item(text_char(), 1, 1));
    endtask

    task automatic drain();
        while (send_q.size() != 0 || status_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [12:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // queue about n items, lines shortened near the end of the budget
    task automatic random_phase(input int n);
        int sent, before_sz, room, len;
        sent = 0;
        while (sent < n) begin
            before_sz = send_q.size();
            room = n - sent;
            case ($urandom_range(0, 9))
                0, 1: send_q.push_back(read_item(pick_index()));
                2: send_q.push_back(feed_item(8'($urandom()), 1'($urandom()), 1'($urandom())));
                3: begin
                    len = $urandom_range(200, 300);
                    queue_line((len < room) ? len : room);
                end
                default: begin
                    len = $urandom_range(0, 40);
                    queue_line((len < room) ? len : room);
                end
            endcase
            sent += send_q.size() - before_sz;
            // let prediction keep pace so read indexes track the store
            while (send_q.size() > 8) @(posedge aclk);
        end
    endtask

    initial begin
        cap_reg = 13'd4096;
        esc_phase = ESC_NONE;
        tail_drop = 1'b0;
        buf_len = 0;
        head_ptr = 0;
        held_bytes = 0;
        held_lines = 0;
        evicted_lines = '0;
        committed_lines = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: escapes, csi cut by newline, cr/nul, cut-off record, reads
        send_q.push_back(read_item(12'd0));
        send_q.push_back(feed_item("a", 0, 0));
        send_q.push_back(feed_item("b", 0, 0));
        send_q.push_back(feed_item(CH_CR, 0, 0));
        send_q.push_back(feed_item(CH_NUL, 0, 1));
        send_q.push_back(feed_item(CH_NL, 1, 0));
        send_q.push_back(feed_item(CH_ESC, 0, 0));
        send_q.push_back(feed_item("x", 0, 0));
        send_q.push_back(feed_item(CH_ESC, 0, 0));
        send_q.push_back(feed_item(CH_LB, 0, 0));
        send_q.push_back(feed_item("1", 0, 0));
        send_q.push_back(feed_item(CH_TIL, 0, 0));
        send_q.push_back(feed_item(8'hFF, 0, 0));
        send_q.push_back(feed_item(CH_ESC, 0, 0));
        send_q.push_back(feed_item(CH_LB, 0, 0));
        send_q.push_back(feed_item(CH_NL, 0, 0));
        send_q.push_back(feed_item("z", 1, 1));
        send_q.push_back(read_item(12'd0));
        send_q.push_back(read_item(12'd2));
        send_q.push_back(read_item(12'd3));
        send_q.push_back(read_item(12'd4095));
        send_q.push_back(feed_item(CH_ESC, 1, 1));
        send_q.push_back(feed_item("q", 1, 1));
        drain();

        random_phase(450);
        drain();
        write_capacity(13'd1);
        queue_line(5);
        random_phase(60);
        drain();
        write_capacity(13'd0);
        random_phase(60);
        drain();
        write_capacity(13'd40);
        random_phase(350);
        drain();
        write_capacity(13'h1FFF);
        random_phase(250);
        drain();
        write_capacity(13'd300);
        random_phase(200);
        drain();
        calm = 1'b1;
        write_capacity(13'd4096);
        random_phase(150);
        drain();

        $display("covered %0d results, %0d reads of stored bytes, %0d lines kept, %0d evicted",
                 results_seen, reads_hit, committed_lines, evicted_lines);
        $display("capacities 4096, 1, 0, 40, 8191, 300 with random stalls on both sides");
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("timeout");
        $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
sv/aslls_pkg.sv
sv/aslls_store_ram.sv
sv/ansi_strip_line_log_store_unit.sv
sv/aslls_checker.sv
tb/sv/tb.sv
